// ===== sv/lpsm_pkg.sv =====
`default_nettype none
package lpsm_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int POOL_SIZE  = 4096;
	localparam int KEY_BITS   = 16;

	localparam int IDX_W    = $clog2(TABLE_SIZE);
	localparam int MODE_W   = 2;
	localparam int KEY_W    = KEY_BITS;
	localparam int SLOT_W   = 12;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 13;
	localparam int ENTRY_W  = KEY_W + SLOT_W;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BIND   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POOL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		logic                found;
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic mark_zero;
		logic advance;
		logic decide;
		logic write;
		logic mark_full;
		logic clr_step;
		logic clr_done;
		logic load_rsp;
	} cmd_t;

	typedef struct packed {
		logic key_zero;
		logic mode_clear;
		logic hit;
		logic need_write;
		logic last_probe;
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/lpsm_ram.sv =====
`default_nettype none
module lpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/lpsm_dp.sv =====
`default_nettype none
module lpsm_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpsm_pkg::req_t           req,
	input  logic                     cfg_we,
	input  logic [lpsm_pkg::CNT_W-1:0] cfg_data,
	input  lpsm_pkg::cmd_t           cmd,
	output lpsm_pkg::sts_t           sts,
	output lpsm_pkg::rsp_t           rsp
);
	import lpsm_pkg::*;

	req_t              req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  probes_q;
	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  limit_q;
	rsp_t              res_q;
	rsp_t              rsp_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [KEY_W-1:0]  rd_key;
	logic [SLOT_W-1:0] rd_slot;
	logic              bound;
	logic              can_alloc;
	logic [CNT_W-1:0]  lim;
	logic [SLOT_W-1:0] wslot;
	rsp_t              dec_res;
	logic              need_write;

	lpsm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_W];
	assign rd_slot   = ram_rdata[SLOT_W-1:0];
	assign bound     = (rd_key != '0);
	assign lim       = (limit_q > CNT_W'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : limit_q;
	assign can_alloc = (used_q < lim);
	assign wslot     = (req_q.mode == MODE_ADD) ? used_q[SLOT_W-1:0] : req_q.slot_in;

	assign need_write = (req_q.mode == MODE_BIND) ||
		((req_q.mode == MODE_ADD) && !bound && can_alloc);

	always_comb begin
		dec_res = '0;
		unique case (req_q.mode)
			MODE_LOOKUP: begin
				dec_res.found  = bound;
				dec_res.slot   = bound ? rd_slot : '0;
				dec_res.status = ST_OK;
			end
			MODE_ADD: begin
				priority if (bound) begin
					dec_res.found  = 1'b1;
					dec_res.slot   = rd_slot;
					dec_res.status = ST_PRESENT;
				end else if (can_alloc) begin
					dec_res.found  = 1'b1;
					dec_res.slot   = used_q[SLOT_W-1:0];
					dec_res.status = ST_OK;
				end else begin
					dec_res.status = ST_POOL;
				end
			end
			MODE_BIND: begin
				dec_res.found  = 1'b1;
				dec_res.slot   = req_q.slot_in;
				dec_res.status = ST_OK;
			end
			MODE_CLEAR: begin
				dec_res = '0;
			end
		endcase
	end

	assign ram_we    = cmd.clr_step | cmd.write;
	assign ram_waddr = cmd.clr_step ? clr_q : idx_q;
	assign ram_wdata = cmd.clr_step ? '0 : {req_q.key, wslot};

	assign sts.key_zero   = (req.key == '0);
	assign sts.mode_clear = (req.mode == MODE_CLEAR);
	assign sts.hit        = !bound || (rd_key == req_q.key);
	assign sts.need_write = need_write;
	assign sts.last_probe = (probes_q == '1);
	assign sts.clr_last   = (clr_q == '1);

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			used_q  <= '0;
			limit_q <= CNT_W'(POOL_SIZE);
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			priority if (cmd.clr_done) begin
				used_q <= '0;
			end else if (cmd.write && (req_q.mode == MODE_ADD)) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req;
			idx_q    <= req.key[IDX_W-1:0];
			probes_q <= '0;
		end else if (cmd.advance) begin
			idx_q    <= idx_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
		priority if (cmd.mark_zero) begin
			res_q <= '{found: 1'b0, slot: '0, status: ST_ZERO};
		end else if (cmd.mark_full) begin
			res_q <= '{found: 1'b0, slot: '0, status: ST_FULL};
		end else if (cmd.clr_done) begin
			res_q <= '{found: 1'b0, slot: '0, status: ST_OK};
		end else if (cmd.decide) begin
			res_q <= dec_res;
		end
		if (cmd.load_rsp) begin
			rsp_q <= res_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lpsm_ctrl.sv =====
`default_nettype none
module lpsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  lpsm_pkg::sts_t sts,
	output lpsm_pkg::cmd_t cmd
);
	import lpsm_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					priority if (sts.mode_clear) begin
						state_d = S_CLEAR;
					end else if (sts.key_zero) begin
						cmd.mark_zero = 1'b1;
						state_d       = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				priority if (sts.hit) begin
					cmd.decide = 1'b1;
					cmd.write  = sts.need_write;
					state_d    = S_DONE;
				end else if (sts.last_probe) begin
					cmd.mark_full = 1'b1;
					state_d       = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_READ;
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.clr_done = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// ===== sv/linear_probe_slot_map_unit.sv =====
// Channel   Handshake                Payload
// req       req_valid / req_stall    req  (mode, key, slot_in)
// rsp       rsp_valid / rsp_stall    rsp  (found, slot, status)
// cfg       cfg_valid / cfg_ready    cfg_data (pool limit)
//
// A non-clear request with a zero key is answered without reading the table; any
// other non-clear request probes table entries in turn, each probe being one read
// of the entry memory and one compare.
// A clear request walks the table one entry per cycle.
// After reset the same walk runs before the first request.
// A stalled response holds in the output register; the next request is taken
// meanwhile and finishes once that register is free.
`default_nettype none
module linear_probe_slot_map_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lpsm_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output lpsm_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lpsm_pkg::CNT_W-1:0] cfg_data
);
	import lpsm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lpsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpsm_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg_we  (cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.sts     (sts),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while the previous one is still in work");

	a_no_slot_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.slot == '0)
		else $error("slot is nonzero on a response without a binding");

	a_present_is_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_PRESENT |-> rsp.found)
		else $error("already-present response without a binding");

	a_error_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ZERO || rsp.status == ST_FULL ||
		rsp.status == ST_POOL) |-> !rsp.found)
		else $error("failed response reports a binding");
`endif

endmodule
`default_nettype wire
